@@ src/spt_pkg.sv @@
// Shared constants and controller/datapath interface types for the spark tachometer.
package spt_pkg;

  localparam int unsigned PERIOD_BITS_DEF = 24;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  localparam int unsigned THR_BITS  = 12;
  localparam int unsigned TPM_BITS  = 24;
  localparam int unsigned RPM_BITS  = 16;
  localparam int unsigned GAIN_BITS = 16;
  localparam int unsigned AVG_BITS  = 32;
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned CFG_DATA_BITS = 24;
  localparam int unsigned CFG_IDX_BITS  = 2;

  localparam int unsigned DIV_CNT_BITS = $clog2(TPM_BITS);

  localparam logic [THR_BITS-1:0]  THRESHOLD_RST = THR_BITS'(3500);
  localparam logic [TPM_BITS-1:0]  TPM_RST       = TPM_BITS'(600000);
  localparam logic [RPM_BITS-1:0]  MAX_RPM_RST   = RPM_BITS'(8000);
  localparam logic [GAIN_BITS-1:0] GAIN_RST      = GAIN_BITS'(3277);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SPARK_THRESHOLD  = 2'd0,
    CFG_TICKS_PER_MINUTE = 2'd1,
    CFG_MAX_RPM          = 2'd2,
    CFG_SMOOTHING_GAIN   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic clamp;
    logic mul;
    logic sum;
  } ctrl_cmd_t;

  typedef struct packed {
    logic spark_period;
    logic div_last;
  } dp_status_t;

endpackage

@@ src/spark_tachometer_smoothed.sv @@
// Top level of the spark tachometer with smoothed RPM output.
// A sample that completes no period gives its result in the cycle after acceptance.
// A sample that completes a period steps through the bit-serial RPM divider, then
// the clamp, multiply and average steps. One sample is in work at a time.
// Samples without a period can be taken every cycle while the output is not stalled.
// Reset (asynchronous, active low) restores defaults and clears the FSM and results.
module spark_tachometer_smoothed #(
  parameter int unsigned PERIOD_BITS = spt_pkg::PERIOD_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = spt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spt_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [spt_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [SAMPLE_BITS-1:0]            adc_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              period_valid_o,
  output logic [PERIOD_BITS-1:0]            period_ticks_o,
  output logic [spt_pkg::RPM_BITS-1:0]      instant_rpm_o,
  output logic [spt_pkg::RPM_BITS-1:0]      smoothed_rpm_o
);

  spt_pkg::ctrl_cmd_t  cmd;
  spt_pkg::dp_status_t status;

  spt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  spt_dpath #(
    .PERIOD_BITS (PERIOD_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .adc_sample_i   (adc_sample_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .period_valid_o (period_valid_o),
    .period_ticks_o (period_ticks_o),
    .instant_rpm_o  (instant_rpm_o),
    .smoothed_rpm_o (smoothed_rpm_o)
  );

endmodule

@@ src/spt_ctrl.sv @@
// Sequencing state machine for the spark tachometer: handshakes, divide, clamp and average steps.
module spt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  spt_pkg::dp_status_t status_i,
  output spt_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_CLAMP = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_SUM   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.accept    = accept;
    out_valid_d     = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (status_i.spark_period) begin
            state_d = ST_DIV;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum   = 1'b1;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/spt_dpath.sv @@
// Datapath for the spark tachometer: configuration, edge detect, period counter, divider and average.
module spt_dpath #(
  parameter int unsigned PERIOD_BITS = spt_pkg::PERIOD_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = spt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [spt_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [spt_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]              adc_sample_i,
  input  spt_pkg::ctrl_cmd_t                  cmd_i,
  output spt_pkg::dp_status_t                 status_o,
  output logic                                period_valid_o,
  output logic [PERIOD_BITS-1:0]              period_ticks_o,
  output logic [spt_pkg::RPM_BITS-1:0]        instant_rpm_o,
  output logic [spt_pkg::RPM_BITS-1:0]        smoothed_rpm_o
);

  localparam int unsigned CMP_BITS =
    (SAMPLE_BITS > spt_pkg::THR_BITS) ? SAMPLE_BITS : spt_pkg::THR_BITS;
  localparam int unsigned GC_BITS  = spt_pkg::GAIN_BITS + 1;
  localparam int unsigned PA_BITS  = GC_BITS + spt_pkg::AVG_BITS;
  localparam int unsigned PB_BITS  = spt_pkg::GAIN_BITS + spt_pkg::RPM_BITS;

  logic [spt_pkg::THR_BITS-1:0]  thr_q;
  logic [spt_pkg::TPM_BITS-1:0]  tpm_q;
  logic [spt_pkg::RPM_BITS-1:0]  max_q;
  logic [spt_pkg::GAIN_BITS-1:0] gain_q;

  logic                          was_above_q;
  logic                          seen_q;
  logic [PERIOD_BITS-1:0]        ticks_q;
  logic [PERIOD_BITS-1:0]        period_q;
  logic [spt_pkg::RPM_BITS-1:0]  inst_q;
  logic [spt_pkg::AVG_BITS-1:0]  avg_q;
  logic                          pv_q;

  logic [spt_pkg::TPM_BITS-1:0]     num_q;
  logic [PERIOD_BITS-1:0]           rem_q;
  logic [spt_pkg::DIV_CNT_BITS-1:0] cnt_q;
  logic [PA_BITS-1:0]               prod_a_q;
  logic [PB_BITS-1:0]               prod_b_q;

  logic [CMP_BITS-1:0]    sample_ext;
  logic [CMP_BITS-1:0]    thr_ext;
  logic                   above;
  logic                   spark;
  logic [PERIOD_BITS-1:0] ticks_inc;
  logic [PERIOD_BITS:0]   rem_sh;
  logic [PERIOD_BITS:0]   rem_sub;
  logic                   rem_ge;
  logic [GC_BITS-1:0]     gain_c;
  logic [spt_pkg::AVG_BITS-1:0] mix;

  assign sample_ext = CMP_BITS'(adc_sample_i);
  assign thr_ext    = CMP_BITS'(thr_q) & CMP_BITS'({SAMPLE_BITS{1'b1}});
  assign above      = sample_ext > thr_ext;
  assign spark      = above && !was_above_q;
  assign ticks_inc  = (ticks_q == {PERIOD_BITS{1'b1}}) ? ticks_q : ticks_q + 1'b1;

  assign rem_sh  = {rem_q, num_q[spt_pkg::TPM_BITS-1]};
  assign rem_ge  = rem_sh >= {1'b0, period_q};
  assign rem_sub = rem_sh - {1'b0, period_q};

  assign gain_c = GC_BITS'(1 << spt_pkg::FRAC_BITS) - GC_BITS'(gain_q);
  assign mix    = spt_pkg::AVG_BITS'(prod_a_q[PA_BITS-1:spt_pkg::FRAC_BITS])
                + spt_pkg::AVG_BITS'(prod_b_q);

  assign status_o.spark_period = spark && seen_q;
  assign status_o.div_last     = cnt_q == spt_pkg::DIV_CNT_BITS'(spt_pkg::TPM_BITS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= spt_pkg::THRESHOLD_RST;
      tpm_q  <= spt_pkg::TPM_RST;
      max_q  <= spt_pkg::MAX_RPM_RST;
      gain_q <= spt_pkg::GAIN_RST;
    end else if (cfg_we_i) begin
      case (spt_pkg::cfg_idx_e'(cfg_idx_i))
        spt_pkg::CFG_SPARK_THRESHOLD:  thr_q  <= cfg_data_i[spt_pkg::THR_BITS-1:0];
        spt_pkg::CFG_TICKS_PER_MINUTE: tpm_q  <= cfg_data_i[spt_pkg::TPM_BITS-1:0];
        spt_pkg::CFG_MAX_RPM:          max_q  <= cfg_data_i[spt_pkg::RPM_BITS-1:0];
        spt_pkg::CFG_SMOOTHING_GAIN:   gain_q <= cfg_data_i[spt_pkg::GAIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_above_q <= 1'b0;
      seen_q      <= 1'b0;
      ticks_q     <= '0;
      period_q    <= '0;
      inst_q      <= '0;
      avg_q       <= '0;
      pv_q        <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        was_above_q <= above;
        seen_q      <= seen_q || spark;
        ticks_q     <= spark ? '0 : ticks_inc;
        pv_q        <= 1'b0;
        if (spark && seen_q) begin
          period_q <= ticks_inc;
        end
      end
      if (cmd_i.clamp) begin
        inst_q <= (num_q > spt_pkg::TPM_BITS'(max_q)) ? max_q
                                                      : num_q[spt_pkg::RPM_BITS-1:0];
      end
      if (cmd_i.sum) begin
        pv_q  <= 1'b1;
        avg_q <= (avg_q == '0) ? {inst_q, {spt_pkg::FRAC_BITS{1'b0}}} : mix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      num_q <= tpm_q;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[spt_pkg::TPM_BITS-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[PERIOD_BITS-1:0] : rem_sh[PERIOD_BITS-1:0];
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.mul) begin
      prod_a_q <= PA_BITS'(gain_c) * PA_BITS'(avg_q);
      prod_b_q <= PB_BITS'(gain_q) * PB_BITS'(inst_q);
    end
  end

  assign period_valid_o = pv_q;
  assign period_ticks_o = period_q;
  assign instant_rpm_o  = inst_q;
  assign smoothed_rpm_o = avg_q[spt_pkg::AVG_BITS-1:spt_pkg::FRAC_BITS];

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the spark tachometer with smoothed RPM output.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PERIOD_W = spt_pkg::PERIOD_BITS_DEF;
  localparam int unsigned SAMPLE_W = spt_pkg::SAMPLE_BITS_DEF;
  localparam logic [PERIOD_W-1:0] TICK_LIMIT = '1;
  localparam int unsigned HOLD_AT_RESULT = 300;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_PHASES = 7;
  localparam int unsigned PHASE_SAMPLES = 200;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic                         period_valid;
    logic [PERIOD_W-1:0]          period_ticks;
    logic [spt_pkg::RPM_BITS-1:0] instant_rpm;
    logic [spt_pkg::RPM_BITS-1:0] smoothed_rpm;
  } tach_result_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [spt_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i = spt_pkg::CFG_SPARK_THRESHOLD;
  logic [spt_pkg::CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic [SAMPLE_W-1:0]               adc_sample_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic                              period_valid_o;
  logic [PERIOD_W-1:0]               period_ticks_o;
  logic [spt_pkg::RPM_BITS-1:0]      instant_rpm_o;
  logic [spt_pkg::RPM_BITS-1:0]      smoothed_rpm_o;

  logic [spt_pkg::THR_BITS-1:0]  thr_cfg = spt_pkg::THRESHOLD_RST;
  logic [spt_pkg::TPM_BITS-1:0]  tpm_cfg = spt_pkg::TPM_RST;
  logic [spt_pkg::RPM_BITS-1:0]  rpm_cap_cfg = spt_pkg::MAX_RPM_RST;
  logic [spt_pkg::GAIN_BITS-1:0] gain_cfg = spt_pkg::GAIN_RST;

  logic                         prev_above = 1'b0;
  logic                         armed = 1'b0;
  logic [PERIOD_W-1:0]          tick_count = '0;
  logic [PERIOD_W-1:0]          held_period = '0;
  logic [spt_pkg::RPM_BITS-1:0] held_rpm = '0;
  logic [spt_pkg::AVG_BITS-1:0] rpm_avg_q16 = '0;

  logic [SAMPLE_W-1:0] pending_samples[$];
  tach_result_t        expected_results[$];
  tach_result_t        want;

  int unsigned fail_count = 0;
  int unsigned checked_results = 0;
  int unsigned send_gap = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  spark_tachometer_smoothed i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .adc_sample_i   (adc_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .period_valid_o (period_valid_o),
    .period_ticks_o (period_ticks_o),
    .instant_rpm_o  (instant_rpm_o),
    .smoothed_rpm_o (smoothed_rpm_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic tach_result_t predict_sample(input logic [SAMPLE_W-1:0] sample);
    tach_result_t                 r;
    logic                         above;
    logic [spt_pkg::TPM_BITS-1:0] quotient;
    logic [63:0]                  mix;
    above = sample > thr_cfg;
    r.period_valid = 1'b0;
    if (tick_count != TICK_LIMIT) begin
      tick_count = tick_count + 1'b1;
    end
    if (above && !prev_above) begin
      if (armed) begin
        held_period = tick_count;
        quotient = tpm_cfg / spt_pkg::TPM_BITS'(held_period);
        if (quotient > spt_pkg::TPM_BITS'(rpm_cap_cfg)) begin
          quotient = spt_pkg::TPM_BITS'(rpm_cap_cfg);
        end
        held_rpm = quotient[spt_pkg::RPM_BITS-1:0];
        if (rpm_avg_q16 == '0) begin
          rpm_avg_q16 = {held_rpm, 16'h0000};
        end else begin
          mix = (64'd65536 - 64'(gain_cfg)) * 64'(rpm_avg_q16)
              + 64'(gain_cfg) * (64'(held_rpm) << spt_pkg::FRAC_BITS);
          rpm_avg_q16 = mix[spt_pkg::FRAC_BITS +: spt_pkg::AVG_BITS];
        end
        r.period_valid = 1'b1;
      end
      armed = 1'b1;
      tick_count = '0;
    end
    prev_above = above;
    r.period_ticks = held_period;
    r.instant_rpm = held_rpm;
    r.smoothed_rpm = rpm_avg_q16[spt_pkg::AVG_BITS-1:spt_pkg::FRAC_BITS];
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(predict_sample(adc_sample_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_valid_i <= 1'b1;
          adc_sample_i <= pending_samples.pop_front();
          if ($urandom_range(0, 99) < send_idle_pct) begin
            send_gap = $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("Unexpected transaction: valid=%0b period=%0d inst=%0d smooth=%0d",
                                 period_valid_o, period_ticks_o, instant_rpm_o, smoothed_rpm_o));
        end else begin
          want = expected_results.pop_front();
          if (period_valid_o !== want.period_valid || period_ticks_o !== want.period_ticks ||
              instant_rpm_o !== want.instant_rpm || smoothed_rpm_o !== want.smoothed_rpm) begin
            note_failure($sformatf({"Result %0d mismatch: expected valid=%0b period=%0d ",
                                    "inst=%0d smooth=%0d, got valid=%0b period=%0d ",
                                    "inst=%0d smooth=%0d"},
                                   checked_results, want.period_valid, want.period_ticks,
                                   want.instant_rpm, want.smoothed_rpm, period_valid_o,
                                   period_ticks_o, instant_rpm_o, smoothed_rpm_o));
          end
        end
        checked_results++;
        if (checked_results == HOLD_AT_RESULT) begin
          hold_cycles = HOLD_CYCLES;
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else if (stall_cycles > 0) begin
        stall_cycles--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
        stall_cycles = $urandom_range(0, 5);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic configure_tach(input int unsigned thr, input int unsigned tpm,
                                input int unsigned rpm_cap, input int unsigned gain);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= spt_pkg::CFG_SPARK_THRESHOLD;
    cfg_data_i <= spt_pkg::CFG_DATA_BITS'(thr);
    @(posedge clk_i);
    cfg_idx_i <= spt_pkg::CFG_TICKS_PER_MINUTE;
    cfg_data_i <= spt_pkg::CFG_DATA_BITS'(tpm);
    @(posedge clk_i);
    cfg_idx_i <= spt_pkg::CFG_MAX_RPM;
    cfg_data_i <= spt_pkg::CFG_DATA_BITS'(rpm_cap);
    @(posedge clk_i);
    cfg_idx_i <= spt_pkg::CFG_SMOOTHING_GAIN;
    cfg_data_i <= spt_pkg::CFG_DATA_BITS'(gain);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thr_cfg = spt_pkg::THR_BITS'(thr);
    tpm_cfg = spt_pkg::TPM_BITS'(tpm);
    rpm_cap_cfg = spt_pkg::RPM_BITS'(rpm_cap);
    gain_cfg = spt_pkg::GAIN_BITS'(gain);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  // Mostly clean pulse trains with random spacing, mixed with noise and chatter at the threshold.
  task automatic queue_random_samples(input int unsigned n_items);
    int unsigned count;
    int unsigned kind;
    int unsigned pulse_len;
    int unsigned gap_len;
    int unsigned thr;
    count = 0;
    thr = thr_cfg;
    while (count < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        repeat ($urandom_range(1, 8)) begin
          pending_samples.push_back(SAMPLE_W'($urandom_range(0, 4095)));
          count++;
        end
      end else if (kind < 16) begin
        repeat ($urandom_range(2, 10)) begin
          pending_samples.push_back(SAMPLE_W'($urandom_range(0, 1) ? thr : thr + 1));
          count++;
        end
      end else begin
        pulse_len = $urandom_range(1, 3);
        gap_len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 200) : $urandom_range(1, 8);
        repeat (pulse_len) begin
          pending_samples.push_back(SAMPLE_W'(($urandom_range(0, 3) == 0) ?
                                              thr + 1 : $urandom_range(thr + 1, 4095)));
        end
        repeat (gap_len) begin
          pending_samples.push_back(SAMPLE_W'(($urandom_range(0, 3) == 0) ?
                                              thr : $urandom_range(0, thr)));
        end
        count += pulse_len + gap_len;
      end
    end
  endtask

  function automatic int unsigned pick_setting(input int unsigned lo, input int unsigned hi);
    int unsigned sel;
    sel = $urandom_range(0, 3);
    if (sel == 0) begin
      return lo;
    end else if (sel == 1) begin
      return hi;
    end
    return $urandom_range(lo, hi);
  endfunction

  initial begin
    int unsigned tpm;
    int unsigned rpm_cap;
    send_idle_pct = 30;
    recv_stall_pct = 20;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pending_samples = '{4095, 3500, 0, 3501, 4095, 0, 4095};
    wait_drained();
    configure_tach(3500, 0, 8000, 65535);
    pending_samples = '{0, 4095, 0, 4095, 0, 4095, 0, 4095};
    wait_drained();
    configure_tach(3500, 600000, 0, 0);
    pending_samples = '{0, 4095, 0, 4095};
    wait_drained();
    configure_tach(0, 16777215, 65535, 0);
    pending_samples = '{1, 0, 1, 0, 1};
    wait_drained();
    configure_tach(4095, 600000, 8000, 32768);
    pending_samples = '{4095, 0, 4095};
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: tpm = $urandom_range(1, 4000);
        1: tpm = 600000;
        default: tpm = pick_setting(1, 16777215);
      endcase
      rpm_cap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : pick_setting(1, 65535);
      configure_tach($urandom_range(1, 4094), tpm, rpm_cap, pick_setting(0, 65535));
      if (p == RANDOM_PHASES - 1) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct = $urandom_range(0, 2) * 20;
        recv_stall_pct = $urandom_range(0, 2) * 15;
      end
      queue_random_samples(PHASE_SAMPLES);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
